[src/keyed_sum_table_sorted_dump_top_defines.svh]
// Assertion helpers included by the top module to check its own logic.
`ifndef KEYED_SUM_TABLE_SORTED_DUMP_TOP_DEFINES_SVH
`define KEYED_SUM_TABLE_SORTED_DUMP_TOP_DEFINES_SVH

// Condition c must hold in the same cycle as a.
`define KSSD_ASSERT_SAME(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("assertion failed");

// Condition c must hold in the cycle after a.
`define KSSD_ASSERT_NEXT(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("assertion failed");

`endif

[src/kssd_pkg.sv]
`default_nettype none
package kssd_pkg;
   localparam int KEY_W   = 64;
   localparam int COUNT_W = 8;
   localparam int TOTAL_W = 32;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 32;

   localparam logic [STAT_W-1:0] ST_ENTRY = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_DUMP = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ENTRY = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SORT_DESC   = 8'd1;
endpackage
`default_nettype wire

[src/kssd_if.sv]
`default_nettype none
interface kssd_req_if import kssd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [KEY_W-1:0]   key;
   logic [COUNT_W-1:0] count_a;
   logic [COUNT_W-1:0] count_b;
   modport source (output valid, req_type, key, count_a, count_b, input ready);
   modport sink   (input valid, req_type, key, count_a, count_b, output ready);
endinterface

interface kssd_rsp_if import kssd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [KEY_W-1:0]   out_key;
   logic [TOTAL_W-1:0] total;
   logic               last;
   modport source (output valid, status, out_key, total, last, input ready);
   modport sink   (input valid, status, out_key, total, last, output ready);
endinterface

interface kssd_csr_if import kssd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/kssd_ram.sv]
`default_nettype none
module kssd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

[src/keyed_sum_table_sorted_dump_top.sv]
`default_nettype none
// Keyed sum table with sorted dump. An add item (req_type 0) sums count_a and
// count_b into the total of the table slot holding its key, or opens a new slot;
// adds whose running index is below first_entry are skipped, and a new key that
// finds all TABLE_DEPTH slots used returns one status-full item. Totals saturate
// at 32 bits. A dump item (req_type 1) returns every slot stably sorted by total
// (ascending, or descending when sort_desc is set), marks the final item
// with last, then clears the table and the running index; an empty table
// returns one status-empty item. All slot reads share the single read port of
// the slot memories. An add searches the used slots in order. A dump of n slots
// ranks each slot against all others and writes it into a sorted copy at its
// rank, then emits the items from that copy while the result side takes them.
// The input is not ready while an item is at work; a finished result waits in
// an output register and does not hold off the next item. No clearing pass
// runs after reset.
`include "keyed_sum_table_sorted_dump_top_defines.svh"
module keyed_sum_table_sorted_dump_top import kssd_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input wire logic clock,
   input wire logic reset,
   kssd_req_if.sink   req_ch,
   kssd_rsp_if.source rsp_ch,
   kssd_csr_if.sink   csr_ch
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   typedef enum logic [11:0] {
      S_IDLE    = 12'b000000000001,
      S_ADD_RD  = 12'b000000000010,
      S_ADD_CMP = 12'b000000000100,
      S_ADD_NEW = 12'b000000001000,
      S_EMPTY   = 12'b000000010000,
      S_RK_LD   = 12'b000000100000,
      S_RK_HOLD = 12'b000001000000,
      S_RK_RD   = 12'b000010000000,
      S_RK_CMP  = 12'b000100000000,
      S_RK_WR   = 12'b001000000000,
      S_DMP_RD  = 12'b010000000000,
      S_DMP_OUT = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers; the write channel is always ready.
   logic [TOTAL_W-1:0] first_entry_ff, first_entry_in;
   logic               sort_desc_ff, sort_desc_in;

   logic [CW-1:0]      used_ff, used_in;
   logic [TOTAL_W-1:0] index_ff, index_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [AW-1:0]      rank_ff, rank_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [COUNT_W:0]   sum_ff, sum_in;
   logic [KEY_W-1:0]   ki_ff, ki_in;
   logic [TOTAL_W-1:0] ti_ff, ti_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]   rsp_key_ff, rsp_key_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic               rsp_last_ff, rsp_last_in;

   // Slot memories and the sorted copy built during a dump.
   logic               tbl_rd_en, key_wr_en, tot_wr_en;
   logic [AW-1:0]      tbl_rd_addr, key_wr_addr, tot_wr_addr;
   logic [KEY_W-1:0]   tbl_key_rd;
   logic [TOTAL_W-1:0] tbl_tot_rd, tot_wr_data;
   logic               srt_rd_en, srt_wr_en;
   logic [KEY_W-1:0]   srt_key_rd;
   logic [TOTAL_W-1:0] srt_tot_rd;

   logic               accept, out_free, j_first;
   logic [TOTAL_W:0]   acc_sum;
   logic [CW-1:0]      i_next, j_next;

   kssd_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_tbl_key (
      .clock(clock), .wr_en(key_wr_en), .wr_addr(key_wr_addr), .wr_data(key_ff),
      .rd_en(tbl_rd_en), .rd_addr(tbl_rd_addr), .rd_data(tbl_key_rd)
   );
   kssd_ram #(.WIDTH(TOTAL_W), .DEPTH(TABLE_DEPTH)) u_tbl_tot (
      .clock(clock), .wr_en(tot_wr_en), .wr_addr(tot_wr_addr), .wr_data(tot_wr_data),
      .rd_en(tbl_rd_en), .rd_addr(tbl_rd_addr), .rd_data(tbl_tot_rd)
   );
   kssd_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_srt_key (
      .clock(clock), .wr_en(srt_wr_en), .wr_addr(rank_ff), .wr_data(ki_ff),
      .rd_en(srt_rd_en), .rd_addr(i_ff[AW-1:0]), .rd_data(srt_key_rd)
   );
   kssd_ram #(.WIDTH(TOTAL_W), .DEPTH(TABLE_DEPTH)) u_srt_tot (
      .clock(clock), .wr_en(srt_wr_en), .wr_addr(rank_ff), .wr_data(ti_ff),
      .rd_en(srt_rd_en), .rd_addr(i_ff[AW-1:0]), .rd_data(srt_tot_rd)
   );

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign accept        = req_ch.valid && req_ch.ready;
   assign csr_ch.ready  = 1'b1;
   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.out_key = rsp_key_ff;
   assign rsp_ch.total  = rsp_total_ff;
   assign rsp_ch.last   = rsp_last_ff;

   assign i_next  = CW'(i_ff + 1'b1);
   assign j_next  = CW'(j_ff + 1'b1);
   assign acc_sum = {1'b0, tbl_tot_rd} + (TOTAL_W + 1)'(sum_ff);

   // The dump compare: does slot j come before slot i in the dump order?
   // Equal totals keep their order of creation.
   always_comb begin
      if (tbl_tot_rd == ti_ff) begin
         j_first = (j_ff < i_ff);
      end else if (sort_desc_ff) begin
         j_first = (tbl_tot_rd > ti_ff);
      end else begin
         j_first = (tbl_tot_rd < ti_ff);
      end
   end

   assign tbl_rd_en   = ((state_ff == S_ADD_RD) && (i_ff != used_ff)) ||
                        (state_ff == S_RK_LD) || (state_ff == S_RK_RD);
   assign tbl_rd_addr = (state_ff == S_RK_RD) ? j_ff[AW-1:0] : i_ff[AW-1:0];
   assign srt_rd_en   = (state_ff == S_DMP_RD);
   assign srt_wr_en   = (state_ff == S_RK_WR);

   always_comb begin
      state_in       = state_ff;
      first_entry_in = first_entry_ff;
      sort_desc_in   = sort_desc_ff;
      used_in        = used_ff;
      index_in       = index_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      rank_in        = rank_ff;
      key_in         = key_ff;
      sum_in         = sum_ff;
      ki_in          = ki_ff;
      ti_in          = ti_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_last_in    = rsp_last_ff;
      key_wr_en      = 1'b0;
      key_wr_addr    = used_ff[AW-1:0];
      tot_wr_en      = 1'b0;
      tot_wr_addr    = used_ff[AW-1:0];
      tot_wr_data    = TOTAL_W'(sum_ff);

      if (csr_ch.valid) begin
         if (csr_ch.index == CSR_FIRST_ENTRY) begin
            first_entry_in = csr_ch.data;
         end else if (csr_ch.index == CSR_SORT_DESC) begin
            sort_desc_in = csr_ch.data[0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in = req_ch.key;
               sum_in = {1'b0, req_ch.count_a} + {1'b0, req_ch.count_b};
               i_in   = '0;
               if (req_ch.req_type == REQ_ADD) begin
                  if (index_ff != '1) begin
                     index_in = index_ff + 1'b1;
                  end
                  if (index_ff >= first_entry_ff) begin
                     state_in = S_ADD_RD;
                  end
               end else if (used_ff == '0) begin
                  index_in = '0;
                  state_in = S_EMPTY;
               end else begin
                  state_in = S_RK_LD;
               end
            end
         end
         S_ADD_RD: begin
            state_in = (i_ff == used_ff) ? S_ADD_NEW : S_ADD_CMP;
         end
         S_ADD_CMP: begin
            if (tbl_key_rd == key_ff) begin
               tot_wr_en   = 1'b1;
               tot_wr_addr = i_ff[AW-1:0];
               tot_wr_data = acc_sum[TOTAL_W] ? '1 : acc_sum[TOTAL_W-1:0];
               state_in    = S_IDLE;
            end else begin
               i_in     = i_next;
               state_in = S_ADD_RD;
            end
         end
         S_ADD_NEW: begin
            if (used_ff != DEPTH_C) begin
               key_wr_en = 1'b1;
               tot_wr_en = 1'b1;
               used_in   = CW'(used_ff + 1'b1);
               state_in  = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FULL;
               rsp_key_in    = key_ff;
               rsp_total_in  = TOTAL_W'(sum_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_EMPTY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_EMPTY;
               rsp_key_in    = '0;
               rsp_total_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RK_LD: begin
            state_in = S_RK_HOLD;
         end
         S_RK_HOLD: begin
            ki_in    = tbl_key_rd;
            ti_in    = tbl_tot_rd;
            j_in     = '0;
            rank_in  = '0;
            state_in = S_RK_RD;
         end
         S_RK_RD: begin
            state_in = S_RK_CMP;
         end
         S_RK_CMP: begin
            if (j_first) begin
               rank_in = AW'(rank_ff + 1'b1);
            end
            j_in     = j_next;
            state_in = (j_next == used_ff) ? S_RK_WR : S_RK_RD;
         end
         S_RK_WR: begin
            if (i_next == used_ff) begin
               i_in     = '0;
               state_in = S_DMP_RD;
            end else begin
               i_in     = i_next;
               state_in = S_RK_LD;
            end
         end
         S_DMP_RD: begin
            state_in = S_DMP_OUT;
         end
         S_DMP_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_ENTRY;
               rsp_key_in    = srt_key_rd;
               rsp_total_in  = srt_tot_rd;
               rsp_last_in   = (i_next == used_ff);
               if (i_next == used_ff) begin
                  used_in  = '0;
                  index_in = '0;
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_next;
                  state_in = S_DMP_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         first_entry_ff <= '0;
         sort_desc_ff   <= 1'b0;
         used_ff        <= '0;
         index_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         first_entry_ff <= first_entry_in;
         sort_desc_ff   <= sort_desc_in;
         used_ff        <= used_in;
         index_ff       <= index_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      rank_ff       <= rank_in;
      key_ff        <= key_in;
      sum_ff        <= sum_in;
      ki_ff         <= ki_in;
      ti_ff         <= ti_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // The slot count never passes the table depth.
   `KSSD_ASSERT_SAME(a_used_bound, 1'b1, used_ff <= DEPTH_C)
   // A dump item always closes the input side in the following cycle.
   `KSSD_ASSERT_NEXT(a_busy_after_dump, accept && (req_ch.req_type == REQ_DUMP), !req_ch.ready)
   // A dump only ranks and emits slots that exist.
   `KSSD_ASSERT_SAME(a_rank_in_table, state_ff == S_RK_WR, CW'(rank_ff) < used_ff)
   // Emitting a dump clears the table only with the final item.
   `KSSD_ASSERT_NEXT(a_clear_on_last, (state_ff == S_DMP_OUT) && out_free,
                     rsp_valid_ff && (rsp_last_ff == (used_ff == '0)))
endmodule
`default_nettype wire
